// ----- hdl/i2c_eeprom_access_sequencer_assert.svh -----
// Assertion macros for the sequencer's RTL; included by ieas_engine.
// Depends on nothing; the including module provides i_clk and i_rst_n.
`ifndef I2C_EEPROM_ACCESS_SEQUENCER_ASSERT_SVH
`define I2C_EEPROM_ACCESS_SEQUENCER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define IEAS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define IEAS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hdl/ieas_pkg.sv -----
// Package for the EEPROM access sequencer: beat types, status codes, constants.
// Depends on nothing.
`default_nettype none

package ieas_pkg;

    localparam int unsigned STORE_DEPTH = 5;

    localparam logic [6:0]  DEV_ADDR_RESET = 7'd80;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;

    // configuration register indexes
    localparam logic CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic CFG_TIMEOUT_LIMIT  = 1'b1;

    // input beat kinds
    localparam logic [1:0] KIND_START_RD = 2'd0;
    localparam logic [1:0] KIND_START_WR = 2'd1;
    localparam logic [1:0] KIND_STATUS   = 2'd2;
    localparam logic [1:0] KIND_TICK     = 2'd3;

    // value width codes
    localparam logic [1:0] WCODE_ONE = 2'd0;
    localparam logic [1:0] WCODE_TWO = 2'd1;

    // bus controller status codes
    localparam logic [7:0] ST_START_SENT   = 8'h08;
    localparam logic [7:0] ST_ADDR_W_ACK   = 8'h18;
    localparam logic [7:0] ST_ADDR_W_NACK  = 8'h20;
    localparam logic [7:0] ST_DATA_TX_ACK  = 8'h28;
    localparam logic [7:0] ST_RESTART_SENT = 8'h10;
    localparam logic [7:0] ST_ADDR_R_ACK   = 8'h40;
    localparam logic [7:0] ST_DATA_RX_ACK  = 8'h50;
    localparam logic [7:0] ST_DATA_RX_NACK = 8'h58;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  width_code;
        logic [7:0]  slot;
        logic [31:0] write_value;
        logic [7:0]  bus_status;
        logic [7:0]  received_byte;
    } t_item;

    typedef struct packed {
        logic        put_valid;
        logic [7:0]  put_byte;
        logic        ctl_start;
        logic        ctl_stop;
        logic        ctl_ack;
        logic        ctl_clear;
        logic        done_res;
        logic        error;
        logic [31:0] read_value;
    } t_result;

    function automatic logic [2:0] width_bytes(input logic [1:0] code);
        logic [2:0] n;
        unique case (code)
            WCODE_ONE: n = 3'd1;
            WCODE_TWO: n = 3'd2;
            default:   n = 3'd4;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/ieas_in_if.sv -----
// Input channel of the sequencer: valid/ready handshake plus item payload.
// Depends on nothing.
`default_nettype none

interface ieas_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [1:0]  width_code;
    logic [7:0]  slot;
    logic [31:0] write_value;
    logic [7:0]  bus_status;
    logic [7:0]  received_byte;

    modport source (
        output valid, kind, width_code, slot, write_value, bus_status, received_byte,
        input  ready
    );
    modport sink (
        input  valid, kind, width_code, slot, write_value, bus_status, received_byte,
        output ready
    );
endinterface

`default_nettype wire

// ----- hdl/ieas_out_if.sv -----
// Result channel of the sequencer: valid/ready handshake plus controller command.
// Depends on nothing.
`default_nettype none

interface ieas_out_if;
    logic        valid;
    logic        ready;
    logic        put_valid;
    logic [7:0]  put_byte;
    logic        ctl_start;
    logic        ctl_stop;
    logic        ctl_ack;
    logic        ctl_clear;
    logic        done_res;
    logic        error;
    logic [31:0] read_value;

    modport source (
        output valid, put_valid, put_byte, ctl_start, ctl_stop, ctl_ack, ctl_clear,
               done_res, error, read_value,
        input  ready
    );
    modport sink (
        input  valid, put_valid, put_byte, ctl_start, ctl_stop, ctl_ack, ctl_clear,
               done_res, error, read_value,
        output ready
    );
endinterface

`default_nettype wire

// ----- hdl/ieas_engine.sv -----
// Transfer state and per-beat decision logic of the EEPROM access sequencer.
// Depends on ieas_pkg and i2c_eeprom_access_sequencer_assert.svh.
`default_nettype none

`include "i2c_eeprom_access_sequencer_assert.svh"

module ieas_engine
    import ieas_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_fire,
    input  wire t_item       i_item,
    input  wire logic [6:0]  i_dev_addr,
    input  wire logic [15:0] i_timeout,
    output t_result          o_res
);

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    logic [1:0]  r_mode,  n_mode;
    logic [1:0]  r_width, n_width;
    logic [2:0]  r_count, n_count;
    logic [15:0] r_ticks, n_ticks;
    logic        r_err_flag, n_err_flag;
    logic [7:0]  r_store [STORE_DEPTH];
    logic [7:0]  n_store [STORE_DEPTH];

    logic [2:0]  nbytes;
    logic [2:0]  start_n;
    logic [2:0]  count_up;
    logic [7:0]  store_byte;
    logic [31:0] assembled;
    logic [31:0] width_mask;
    logic        rd;
    logic        busy;

    always_comb begin
        nbytes     = width_bytes(r_width);
        start_n    = width_bytes(i_item.width_code);
        count_up   = (r_count == 3'd7) ? r_count : r_count + 3'd1;
        store_byte = (r_count < 3'(STORE_DEPTH)) ? r_store[r_count] : 8'd0;
        unique case (r_width)
            WCODE_ONE: width_mask = 32'h0000_00FF;
            WCODE_TWO: width_mask = 32'h0000_FFFF;
            default:   width_mask = 32'hFFFF_FFFF;
        endcase
        assembled = {r_store[4], r_store[3], r_store[2], r_store[1]} & width_mask;
        rd        = (r_mode == MODE_READ);
        busy      = (r_mode != MODE_IDLE);
    end

    always_comb begin
        n_mode     = r_mode;
        n_width    = r_width;
        n_count    = r_count;
        n_ticks    = r_ticks;
        n_err_flag = r_err_flag;
        n_store    = r_store;
        o_res      = '0;

        unique case (i_item.kind)
            KIND_START_RD, KIND_START_WR: begin
                n_width    = i_item.width_code;
                n_count    = 3'd0;
                n_ticks    = 16'd0;
                n_err_flag = 1'b0;
                // word address: slot scaled by the value width, wrapping
                unique case (i_item.width_code)
                    WCODE_ONE: n_store[0] = i_item.slot;
                    WCODE_TWO: n_store[0] = {i_item.slot[6:0], 1'b0};
                    default:   n_store[0] = {i_item.slot[5:0], 2'b00};
                endcase
                if (i_item.kind == KIND_START_WR) begin
                    for (int i = 1; i < STORE_DEPTH; i++) begin
                        if (3'(i) <= start_n) begin
                            n_store[i] = i_item.write_value[8*(i-1) +: 8];
                        end
                    end
                    n_mode = MODE_WRITE;
                end else begin
                    n_mode = MODE_READ;
                end
                o_res.ctl_start = 1'b1;
            end
            KIND_STATUS: begin
                if (busy) begin
                    unique case (i_item.bus_status)
                        ST_START_SENT: begin
                            o_res.put_valid = 1'b1;
                            o_res.put_byte  = {i_dev_addr, 1'b0};
                            o_res.ctl_clear = 1'b1;
                        end
                        ST_ADDR_W_ACK: begin
                            o_res.put_valid = 1'b1;
                            o_res.put_byte  = store_byte;
                            o_res.ctl_clear = 1'b1;
                            n_count         = count_up;
                        end
                        ST_ADDR_W_NACK: begin
                            o_res.ctl_start = 1'b1;
                            o_res.ctl_stop  = 1'b1;
                            o_res.ctl_clear = 1'b1;
                        end
                        ST_DATA_TX_ACK: begin
                            o_res.ctl_clear = 1'b1;
                            if (rd) begin
                                o_res.ctl_start = 1'b1;
                            end else if (r_count <= nbytes) begin
                                o_res.put_valid = 1'b1;
                                o_res.put_byte  = store_byte;
                                n_count         = count_up;
                            end else begin
                                o_res.ctl_stop = 1'b1;
                                o_res.done_res = 1'b1;
                                n_mode         = MODE_IDLE;
                            end
                        end
                        ST_RESTART_SENT: begin
                            if (rd) begin
                                o_res.put_valid = 1'b1;
                                o_res.put_byte  = {i_dev_addr, 1'b1};
                                o_res.ctl_clear = 1'b1;
                            end
                        end
                        ST_ADDR_R_ACK: begin
                            if (rd) begin
                                o_res.ctl_ack   = 1'b1;
                                o_res.ctl_clear = 1'b1;
                            end
                        end
                        ST_DATA_RX_ACK: begin
                            if (rd) begin
                                // drop bytes past the store, acknowledge while value bytes remain
                                if (r_count < 3'(STORE_DEPTH)) begin
                                    n_store[r_count] = i_item.received_byte;
                                end
                                n_count         = count_up;
                                o_res.ctl_ack   = (count_up <= nbytes);
                                o_res.ctl_clear = 1'b1;
                            end
                        end
                        ST_DATA_RX_NACK: begin
                            if (rd) begin
                                o_res.ctl_stop   = 1'b1;
                                o_res.ctl_clear  = 1'b1;
                                o_res.done_res   = 1'b1;
                                o_res.read_value = assembled;
                                n_mode           = MODE_IDLE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            KIND_TICK: begin
                if (busy) begin
                    if (r_ticks >= i_timeout) begin
                        n_err_flag       = 1'b1;
                        o_res.done_res   = 1'b1;
                        o_res.error      = 1'b1;
                        o_res.read_value = rd ? assembled : 32'd0;
                        n_mode           = MODE_IDLE;
                    end else begin
                        n_ticks = r_ticks + 16'd1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_width    <= 2'd0;
            r_count    <= 3'd0;
            r_ticks    <= 16'd0;
            r_err_flag <= 1'b0;
        end else if (i_fire) begin
            r_mode     <= n_mode;
            r_width    <= n_width;
            r_count    <= n_count;
            r_ticks    <= n_ticks;
            r_err_flag <= n_err_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_store <= n_store;
        end
    end

    `IEAS_ASSERT(a_done_goes_idle, (i_fire && o_res.done_res) |=> (r_mode == MODE_IDLE), "transfer still active after done")
    `IEAS_ASSERT(a_timeout_sets_flag, (i_fire && o_res.error) |=> r_err_flag, "timeout did not set error flag")
    `IEAS_ASSERT(a_start_clears, (i_fire && (i_item.kind == KIND_START_RD || i_item.kind == KIND_START_WR)) |=> (r_count == 3'd0 && r_ticks == 16'd0 && !r_err_flag), "start did not clear transfer state")
    `IEAS_ASSERT(a_ack_only_reading, (i_fire && o_res.ctl_ack) |-> (r_mode == MODE_READ), "acknowledge outside a read")

endmodule

`default_nettype wire

// ----- hdl/i2c_eeprom_access_sequencer.sv -----
// A beat passes through the input register, then the result register.
// Throughput: one beat per cycle, sustained while results are taken. Input
// ready follows result ready combinationally; while a result waits, the input
// takes one more beat only if the input register is empty. Reset (synchronous,
// active low) drops ready and clears handshake, transfer and configuration
// state; the byte store is kept.
`default_nettype none

module i2c_eeprom_access_sequencer
    import ieas_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    ieas_in_if.sink          i_in,
    ieas_out_if.source       o_out,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);

    // configuration registers
    logic [6:0]  r_dev_addr;
    logic [15:0] r_timeout;

    // input register stage
    logic        r_s1_valid;
    t_item       r_s1_item;
    t_item       n_s1_item;

    // result register stage
    logic        r_out_valid;
    t_result     r_out_res;
    t_result     engine_res;

    logic        in_fire;
    logic        s1_adv;

    // Advance the input stage into the result register when that register is
    // empty or being drained this cycle.
    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = i_rst_n && (!r_s1_valid || s1_adv);
    assign in_fire    = i_in.valid && i_in.ready;

    always_comb begin
        n_s1_item.kind          = i_in.kind;
        n_s1_item.width_code    = i_in.width_code;
        n_s1_item.slot          = i_in.slot;
        n_s1_item.write_value   = i_in.write_value;
        n_s1_item.bus_status    = i_in.bus_status;
        n_s1_item.received_byte = i_in.received_byte;
    end

    // The user must make configuration writes only while idle; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= DEV_ADDR_RESET;
            r_timeout  <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEVICE_ADDRESS: r_dev_addr <= i_cfg_data[6:0];
                CFG_TIMEOUT_LIMIT:  r_timeout  <= i_cfg_data;
            endcase
        end
    end

    // Handshake state for both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: hold until the next beat moves in.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item <= n_s1_item;
        end
        if (s1_adv) begin
            r_out_res <= engine_res;
        end
    end

    // Decision logic and transfer state; state commits as the beat leaves
    // the input register.
    ieas_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (s1_adv),
        .i_item     (r_s1_item),
        .i_dev_addr (r_dev_addr),
        .i_timeout  (r_timeout),
        .o_res      (engine_res)
    );

    // Drive the result channel straight from the result register.
    assign o_out.valid      = r_out_valid;
    assign o_out.put_valid  = r_out_res.put_valid;
    assign o_out.put_byte   = r_out_res.put_byte;
    assign o_out.ctl_start  = r_out_res.ctl_start;
    assign o_out.ctl_stop   = r_out_res.ctl_stop;
    assign o_out.ctl_ack    = r_out_res.ctl_ack;
    assign o_out.ctl_clear  = r_out_res.ctl_clear;
    assign o_out.done_res   = r_out_res.done_res;
    assign o_out.error      = r_out_res.error;
    assign o_out.read_value = r_out_res.read_value;

endmodule

`default_nettype wire
